// ===== rtl/lcda_pkg.sv =====
// ----------------------------------------------------------------------------
// lcda_pkg: shared types and constants
// Widths, codes and the per-item command word passed from the controller
// to the datapath of the lifetime curve drop analyzer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcda_pkg;

  localparam int COUNT_W = 48;
  localparam int IDX_W   = 5;
  localparam int STEP_W  = 4;
  localparam int DEC_W   = 5;

  localparam logic signed [DEC_W-1:0] DECISION_CONFLICT = -5'sd1;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [STEP_W-1:0] step;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lcda_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcda_ctrl: group sequencer
// Tracks the position of each accepted item within its group and issues
// one registered command per item to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lcda_ctrl #(
  parameter int GEN_COUNT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  output lcda_pkg::cmd_t      cmd
);

  typedef enum logic {
    S_FIRST,
    S_REST
  } state_t;

  localparam logic [lcda_pkg::IDX_W-1:0] LAST_IDX = lcda_pkg::IDX_W'(GEN_COUNT - 1);

  state_t                       state;
  logic [lcda_pkg::IDX_W-1:0]   entry_index;
  logic [lcda_pkg::IDX_W-1:0]   step_full;

  assign step_full = entry_index - lcda_pkg::IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FIRST;
      entry_index <= '0;
      cmd         <= '0;
    end else begin
      cmd.valid <= accept;
      cmd.first <= 1'b0;
      cmd.last  <= 1'b0;
      cmd.step  <= step_full[lcda_pkg::STEP_W-1:0];
      if (accept) begin
        unique case (state)
          S_FIRST: begin
            cmd.first   <= 1'b1;
            entry_index <= lcda_pkg::IDX_W'(1);
            state       <= S_REST;
          end
          S_REST: begin
            if (entry_index == LAST_IDX) begin
              cmd.last    <= 1'b1;
              entry_index <= '0;
              state       <= S_FIRST;
            end else begin
              entry_index <= entry_index + lcda_pkg::IDX_W'(1);
            end
          end
          default: state <= S_FIRST;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcda_datapath.sv =====
// ----------------------------------------------------------------------------
// lcda_datapath: fall measurement and drop tracking
// Stage one forms the fall from the previous count, stage two applies the
// one-tenth test, tracks the steepest drop and registers the decision.
// ----------------------------------------------------------------------------
`default_nettype none

module lcda_datapath #(
  parameter int GEN_COUNT = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic [lcda_pkg::COUNT_W-1:0]       count,
  input  wire lcda_pkg::cmd_t                     cmd,
  output logic                                    strobe,
  output logic signed [lcda_pkg::DEC_W-1:0]       decision
);

  localparam int CW = lcda_pkg::COUNT_W;
  localparam int IW = lcda_pkg::IDX_W;
  localparam int SW = lcda_pkg::STEP_W;
  localparam logic [IW-1:0] NO_DROP = IW'(GEN_COUNT);

  logic [CW-1:0] previous_count;
  logic [CW-1:0] count_q;
  logic [CW:0]   diff_q;

  logic [CW-1:0] base_total;
  logic [IW-1:0] last_drop_index;
  logic [SW-1:0] best_index;
  logic [CW-1:0] best_step;
  logic          conflict_seen;

  logic [CW-1:0] fall;
  logic [CW+3:0] fall_x10;
  logic          is_fall;
  logic          is_drop;
  logic [IW-1:0] step_ext;
  logic          conflict_next;
  logic [SW-1:0] best_index_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      previous_count <= count;
      count_q        <= count;
      diff_q         <= {1'b0, previous_count} - {1'b0, count};
    end
  end

  assign fall     = diff_q[CW-1:0];
  assign is_fall  = !diff_q[CW] && (fall != '0);
  assign fall_x10 = {1'b0, fall, 3'b000} + {3'b000, fall, 1'b0};
  assign is_drop  = is_fall && (fall_x10 >= {4'b0000, base_total});
  assign step_ext = IW'(cmd.step);

  always_comb begin
    conflict_next   = conflict_seen;
    best_index_next = best_index;
    if (is_drop) begin
      if (last_drop_index != NO_DROP && step_ext != last_drop_index + IW'(1)) begin
        conflict_next = 1'b1;
      end
      if (fall > best_step) begin
        best_index_next = cmd.step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_total      <= '0;
      last_drop_index <= NO_DROP;
      best_index      <= '0;
      best_step       <= '0;
      conflict_seen   <= 1'b0;
      strobe          <= 1'b0;
    end else begin
      strobe <= cmd.valid && cmd.last;
      if (cmd.valid) begin
        if (cmd.first) begin
          base_total      <= count_q;
          last_drop_index <= NO_DROP;
          best_index      <= '0;
          best_step       <= '0;
          conflict_seen   <= 1'b0;
        end else if (is_drop) begin
          last_drop_index <= step_ext;
          conflict_seen   <= conflict_next;
          best_index      <= best_index_next;
          if (fall > best_step) begin
            best_step <= fall;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.last) begin
      if (base_total == '0) begin
        decision <= '0;
      end else if (conflict_next) begin
        decision <= lcda_pkg::DECISION_CONFLICT;
      end else begin
        decision <= $signed({1'b0, best_index_next});
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lifetime_curve_drop_analyzer.sv =====
// ----------------------------------------------------------------------------
// lifetime_curve_drop_analyzer: top level
// Finds the steepest consecutive drop of a survival curve.
// ----------------------------------------------------------------------------
// Each item is one count of a curve; a group holds GEN_COUNT items, the first
// being the total allocation count. An item is taken when start is high and
// busy is low. Busy stays low, so one item may be given in every cycle.
// One decision is produced per group after its last item is taken: the fall
// is formed in the first stage, and the drop test, the running maximum and
// the decision are resolved in the second stage. Throughput is one item per
// cycle, set by the drop tracking loop in the datapath. The decision is
// marked by strobe, which is high for exactly one cycle; the receiver cannot
// hold it off and must take it then. Reset clears the group position and all
// drop tracking, so the next item after reset starts a new group.
// ----------------------------------------------------------------------------
`default_nettype none

module lifetime_curve_drop_analyzer #(
  parameter int GEN_COUNT = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [lcda_pkg::COUNT_W-1:0]       count,
  output logic                                    strobe,
  output logic signed [lcda_pkg::DEC_W-1:0]       decision
);

  logic           accept;
  lcda_pkg::cmd_t cmd;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  lcda_ctrl #(
    .GEN_COUNT(GEN_COUNT)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .cmd   (cmd)
  );

  lcda_datapath #(
    .GEN_COUNT(GEN_COUNT)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .count   (count),
    .cmd     (cmd),
    .strobe  (strobe),
    .decision(decision)
  );

endmodule

`default_nettype wire

// ===== rtl/lcda_checker.sv =====
// ----------------------------------------------------------------------------
// lcda_port_checks: port-level checks
// Watches the top-level ports for timing and range of decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module lcda_port_checks #(
  parameter int GEN_COUNT = 16
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               strobe,
  input wire logic signed [lcda_pkg::DEC_W-1:0]  decision
);

  logic accepted;
  assign accepted = start && !busy;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe raised right after reset");

  a_item_before: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accepted, 2))
    else $error("decision without an item taken two cycles before");

  a_spaced: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("decisions on back-to-back cycles");

  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (decision == lcda_pkg::DECISION_CONFLICT ||
                (decision >= 0 && decision <= GEN_COUNT - 2)))
    else $error("decision out of range");

endmodule

bind lifetime_curve_drop_analyzer lcda_port_checks #(.GEN_COUNT(GEN_COUNT)) u_lcda_checker (.*);

`default_nettype wire
